// ----- hdl/tcpq_pkg.sv -----
// Shared types, codes and sizes for the three-class priority queue.
package tcpq_pkg;

   localparam int DEPTH_PER_CLASS = 16;
   localparam int VALUE_WIDTH     = 32;
   localparam int NUM_CLASSES     = 3;

   localparam int PTR_W   = $clog2(DEPTH_PER_CLASS);
   localparam int CNT_W   = $clog2(DEPTH_PER_CLASS + 1);
   localparam int TOTAL_W = $clog2(NUM_CLASSES * DEPTH_PER_CLASS + 1);
   localparam int CLASS_W = 2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [CLASS_W-1:0]            class_code_type;
   typedef logic [CNT_W-1:0]              count_type;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam class_code_type CLASS_HIGH    = 2'd0;
   localparam class_code_type CLASS_MEDIUM  = 2'd1;
   localparam class_code_type CLASS_LOW     = 2'd2;
   localparam class_code_type CLASS_INVALID = 2'd3;

   typedef enum logic [2:0] {
      ST_PUSHED       = 3'd0,
      ST_POPPED       = 3'd1,
      ST_POP_EMPTY    = 3'd2,
      ST_BAD_PRIORITY = 3'd3,
      ST_CLASS_FULL   = 3'd4
   } status_type;

   typedef struct packed {
      logic           kind;
      value_type      value;
      class_code_type priority_req;
   } req_type;

   typedef struct packed {
      status_type           status;
      value_type            popped_value;
      class_code_type       popped_class;
      count_type            count_high;
      count_type            count_medium;
      count_type            count_low;
      logic [TOTAL_W-1:0]   total_count;
      logic                 head_valid;
      value_type            head_value;
      class_code_type       head_class;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ring_cmd_type;

   typedef struct packed {
      count_type fill;
      value_type head;
   } ring_state_type;

endpackage

// ----- hdl/tcpq_ring.sv -----
// One class ring: storage, pointers, fill count and a registered head entry.
module tcpq_ring
   import tcpq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ring_cmd_type   cmd,
   input  value_type      wdata,
   output ring_state_type state
);

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   count_type        fill_ff, fill_in;
   value_type        head_ff;
   value_type        ring_mem_ff [DEPTH_PER_CLASS];

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH_PER_CLASS - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      rd_ptr_in = cmd.pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = cmd.push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      fill_in   = fill_ff;
      if (cmd.push) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // The read port always follows the next read pointer, so head_ff holds the
   // oldest entry. A push into an empty ring lands at that address and is
   // forwarded past the memory.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         ring_mem_ff[wr_ptr_ff] <= wdata;
      end
      if (cmd.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= wdata;
      end else begin
         head_ff <= ring_mem_ff[rd_ptr_in];
      end
   end

   assign state.fill = fill_ff;
   assign state.head = head_ff;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (fill_ff != CNT_W'(DEPTH_PER_CLASS)))
      else $error("push into a full class ring");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (fill_ff != '0))
      else $error("pop from an empty class ring");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("push and pop in the same cycle");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("empty ring with unequal pointers");

endmodule

// ----- hdl/three_class_priority_queue_top.sv -----
// Top level of the three-class strict-priority queue.
//
// A transaction is accepted at a rising edge where start is high and busy is
// low; req_data carries kind (push or pop), value and priority_req. Busy is
// high during reset and for the first cycle after it, so from then on one
// transaction can be accepted every cycle.
// Every transaction gives exactly one result: rsp_valid is high for one cycle
// with rsp_data, carrying the status, the popped value and class, the three
// class counts, their total and the head of the queue after the operation.
// The receiver cannot hold results off.
//
// An accepted transaction is first held in the request register; stage one
// applies the operation to the class rings; stage two samples the updated
// counts and the ring head registers, whose memory read port is registered.
// Throughput is one transaction per cycle.
//
// Reset clears all pointers and counts, so the queue starts empty; the stored
// entries themselves are not cleared and no reset sweep is needed.
module three_class_priority_queue_top
   import tcpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic           busy_ff;
   logic           req_valid_ff;
   req_type        req_ff;

   logic           mid_valid_ff;
   status_type     mid_status_ff, mid_status_in;
   value_type      mid_pval_ff, mid_pval_in;
   class_code_type mid_pclass_ff, mid_pclass_in;

   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff, rsp_data_in;

   ring_cmd_type   ring_cmd   [NUM_CLASSES];
   ring_state_type ring_state [NUM_CLASSES];

   for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_ring
      tcpq_ring u_ring (
         .clock (clock),
         .reset (reset),
         .cmd   (ring_cmd[g]),
         .wdata (req_ff.value),
         .state (ring_state[g])
      );
   end

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         req_valid_ff <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy_ff;
         mid_valid_ff <= req_valid_ff;
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_ff <= req_data;
      end
      mid_status_ff <= mid_status_in;
      mid_pval_ff   <= mid_pval_in;
      mid_pclass_ff <= mid_pclass_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Operation decode against the ring state before the transaction.
   always_comb begin
      logic           any_full;
      logic           pop_found;
      class_code_type pop_class;
      value_type      pop_head;

      any_full  = 1'b0;
      pop_found = 1'b0;
      pop_class = CLASS_HIGH;
      pop_head  = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (ring_state[c].fill != '0) begin
            pop_found = 1'b1;
            pop_class = CLASS_W'(c);
            pop_head  = ring_state[c].head;
         end
         if ((req_ff.priority_req == CLASS_W'(c)) &&
             (ring_state[c].fill == CNT_W'(DEPTH_PER_CLASS))) begin
            any_full = 1'b1;
         end
      end

      for (int c = 0; c < NUM_CLASSES; c++) begin
         ring_cmd[c] = '0;
      end
      mid_status_in = ST_POP_EMPTY;
      mid_pval_in   = '0;
      mid_pclass_in = CLASS_HIGH;

      if (req_ff.kind == KIND_POP) begin
         if (pop_found) begin
            mid_status_in = ST_POPPED;
            mid_pval_in   = pop_head;
            mid_pclass_in = pop_class;
            for (int c = 0; c < NUM_CLASSES; c++) begin
               ring_cmd[c].pop = req_valid_ff && (pop_class == CLASS_W'(c));
            end
         end
      end else if (req_ff.priority_req == CLASS_INVALID) begin
         mid_status_in = ST_BAD_PRIORITY;
      end else if (any_full) begin
         mid_status_in = ST_CLASS_FULL;
      end else begin
         mid_status_in = ST_PUSHED;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            ring_cmd[c].push = req_valid_ff && (req_ff.priority_req == CLASS_W'(c));
         end
      end
   end

   // Result build from the state after the transaction.
   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.status       = mid_status_ff;
      rsp_data_in.popped_value = mid_pval_ff;
      rsp_data_in.popped_class = mid_pclass_ff;
      rsp_data_in.count_high   = ring_state[CLASS_HIGH].fill;
      rsp_data_in.count_medium = ring_state[CLASS_MEDIUM].fill;
      rsp_data_in.count_low    = ring_state[CLASS_LOW].fill;
      rsp_data_in.total_count  = TOTAL_W'(ring_state[CLASS_HIGH].fill)
                               + TOTAL_W'(ring_state[CLASS_MEDIUM].fill)
                               + TOTAL_W'(ring_state[CLASS_LOW].fill);
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (ring_state[c].fill != '0) begin
            rsp_data_in.head_valid = 1'b1;
            rsp_data_in.head_value = ring_state[c].head;
            rsp_data_in.head_class = CLASS_W'(c);
         end
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted transaction without a result three cycles later");

   a_pop_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_POPPED)) |->
         ((rsp_data.popped_value == '0) && (rsp_data.popped_class == CLASS_HIGH)))
      else $error("popped fields set on a result that is not a pop");

   a_head_matches_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.head_valid == (rsp_data.total_count != '0)))
      else $error("head valid disagrees with the total count");

endmodule
